FILE: rtl/rpt_pkg.sv
// Shared types and constants for the route pattern tokenizer.
`default_nettype none
package rpt_pkg;

  localparam int MAX_PATTERN_LEN = 4096;
  localparam int MAX_TOKENS      = 256;
  localparam int NUMBER_WIDTH    = 32;
  localparam int POS_W           = $clog2(MAX_PATTERN_LEN) + 1;
  localparam int TOK_W           = $clog2(MAX_TOKENS) + 1;
  localparam int TEXT_W          = 12;
  localparam int INDEX_W         = 8;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [3:0] {
    KIND_MATCH     = 4'd0,
    KIND_CAP_END   = 4'd1,
    KIND_CAP_CHAR  = 4'd2,
    KIND_CAP_LEN   = 4'd3,
    KIND_FIND_FWD  = 4'd4,
    KIND_FIND_REV  = 4'd5,
    KIND_JUMP_FWD  = 4'd6,
    KIND_JUMP_BACK = 4'd7,
    KIND_JUMP_END  = 4'd8,
    KIND_JUMP_ABS  = 4'd9
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE      = 5'd0,
    S_DOLLAR    = 5'd1,
    S_LIT       = 5'd2,
    S_BRACE     = 5'd3,
    S_CC_CH     = 5'd4,
    S_CC_Q      = 5'd5,
    S_CC_B      = 5'd6,
    S_CL_NUM    = 5'd7,
    S_BRACKET   = 5'd8,
    S_FWD       = 5'd9,
    S_FF_CH     = 5'd10,
    S_FF_Q      = 5'd11,
    S_FF_B      = 5'd12,
    S_JF_NUM    = 5'd13,
    S_REV       = 5'd14,
    S_FR_CH     = 5'd15,
    S_FR_Q      = 5'd16,
    S_FR_B      = 5'd17,
    S_JB_NUM    = 5'd18,
    S_E1        = 5'd19,
    S_E2        = 5'd20,
    S_END_AFTER = 5'd21,
    S_END_NUM   = 5'd22,
    S_ABS_NUM   = 5'd23
  } lex_state_t;

  typedef struct packed {
    lex_state_t              state;
    logic [NUMBER_WIDTH-1:0] acc;
    logic [7:0]              held;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        lit_start;
    logic [TOK_W-1:0]        tokens;
  } lex_ctx_t;

  typedef struct packed {
    kind_t                   token_kind;
    logic                    syntax_error;
    logic [7:0]              target_char;
    logic [NUMBER_WIDTH-1:0] number_value;
    logic [TEXT_W-1:0]       text_start;
    logic [TEXT_W-1:0]       text_length;
    logic [INDEX_W-1:0]      token_index;
    logic                    final_result;
  } token_t;

endpackage
`default_nettype wire

FILE: rtl/rpt_if.sv
// Valid/ready channel interfaces for pattern bytes and tokens.
`default_nettype none
interface rpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_byte;
  logic       end_of_pattern;

  modport source (output valid, output pattern_byte, output end_of_pattern, input ready);
  modport sink (input valid, input pattern_byte, input end_of_pattern, output ready);
endinterface

interface rpt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic        syntax_error;
  logic [7:0]  target_char;
  logic [31:0] number_value;
  logic [11:0] text_start;
  logic [11:0] text_length;
  logic [7:0]  token_index;
  logic        final_result;

  modport source (output valid, output token_kind, output syntax_error, output target_char,
                  output number_value, output text_start, output text_length,
                  output token_index, output final_result, input ready);
  modport sink (input valid, input token_kind, input syntax_error, input target_char,
                input number_value, input text_start, input text_length,
                input token_index, input final_result, output ready);
endinterface
`default_nettype wire

FILE: rtl/route_pattern_tokenizer_core.sv
// A token word is registered: it appears in the cycle after the byte that closes it is accepted.
// Throughput: one pattern byte per cycle; the lexer state and the token register
// update in the same cycle, and input is held only while an unread token is stalled.
// Reset (synchronous, rst high) returns the lexer to idle expecting a dollar sign
// and empties the token register.
`default_nettype none
module route_pattern_tokenizer_core
  import rpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rpt_in_if.sink    pattern,
  rpt_out_if.source token
);

  lex_ctx_t ctx;
  lex_ctx_t ctx_next;
  lex_ctx_t lex_ctx_out;
  lex_ctx_t ctx_clear;
  logic     discarding;
  logic     discarding_next;
  logic     lex_err;
  logic     lex_emit;
  token_t   lex_tok;
  token_t   out_tok;
  logic     out_valid;
  logic     out_valid_next;
  logic     accept;
  logic     produce;

  rpt_lexer u_lexer (
    .ctx            (ctx),
    .pattern_byte   (pattern.pattern_byte),
    .end_of_pattern (pattern.end_of_pattern),
    .ctx_next       (lex_ctx_out),
    .err            (lex_err),
    .emit           (lex_emit),
    .tok            (lex_tok)
  );

  assign pattern.ready = !out_valid || token.ready;
  assign accept        = pattern.valid && pattern.ready;
  assign produce       = accept && !discarding && (lex_err || lex_emit);

  always_comb begin
    ctx_clear           = '0;
    ctx_clear.state     = S_IDLE;
    ctx_next            = ctx;
    discarding_next     = discarding;
    if (accept) begin
      if (discarding) begin
        // drop words until the end of the pattern
        if (pattern.end_of_pattern) begin
          ctx_next        = ctx_clear;
          discarding_next = 1'b0;
        end
      end else if (lex_err) begin
        ctx_next        = ctx_clear;
        discarding_next = !pattern.end_of_pattern;
      end else if (lex_emit && pattern.end_of_pattern) begin
        ctx_next = ctx_clear;
      end else begin
        ctx_next = lex_ctx_out;
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_next = produce;
    end else if (token.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state     <= S_IDLE;
      ctx.acc       <= '0;
      ctx.held      <= '0;
      ctx.pos       <= '0;
      ctx.lit_start <= '0;
      ctx.tokens    <= '0;
      discarding    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      ctx        <= ctx_next;
      discarding <= discarding_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload register, loaded only with a fresh token
  always_ff @(posedge clk) begin
    if (produce) begin
      out_tok <= lex_tok;
    end
  end

  assign token.valid        = out_valid;
  assign token.token_kind   = out_tok.token_kind;
  assign token.syntax_error = out_tok.syntax_error;
  assign token.target_char  = out_tok.target_char;
  assign token.number_value = out_tok.number_value;
  assign token.text_start   = out_tok.text_start;
  assign token.text_length  = out_tok.text_length;
  assign token.token_index  = out_tok.token_index;
  assign token.final_result = out_tok.final_result;

endmodule
`default_nettype wire

FILE: rtl/rpt_digit_acc.sv
// Saturating decimal digit accumulator: base * 10 + digit.
`default_nettype none
module rpt_digit_acc
  import rpt_pkg::*;
(
  input  wire logic [NUMBER_WIDTH-1:0] base,
  input  wire logic [7:0]              digit_char,
  output logic [NUMBER_WIDTH-1:0]      result
);

  logic [3:0]              digit;
  logic [NUMBER_WIDTH+3:0] wide;

  always_comb begin
    digit = 4'(digit_char - CH_ZERO);
    // times ten as shift-and-add
    wide = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {{NUMBER_WIDTH{1'b0}}, digit};
    if (wide[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'd0) begin
      result = {NUMBER_WIDTH{1'b1}};
    end else begin
      result = wide[NUMBER_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rpt_lexer.sv
// Next-state and token logic for one pattern byte.
`default_nettype none
module rpt_lexer
  import rpt_pkg::*;
(
  input  wire lex_ctx_t   ctx,
  input  wire logic [7:0] pattern_byte,
  input  wire logic       end_of_pattern,
  output lex_ctx_t        ctx_next,
  output logic            err,
  output logic            emit,
  output token_t          tok
);

  logic                    is_dig;
  logic                    clear_acc;
  logic [NUMBER_WIDTH-1:0] acc_base;
  logic [NUMBER_WIDTH-1:0] acc_digit;
  logic                    err_syntax;
  kind_t                   kind;
  logic [7:0]              ch;
  logic [NUMBER_WIDTH-1:0] num;
  logic [POS_W-1:0]        tstart;
  logic [POS_W-1:0]        tlen;

  assign is_dig    = (pattern_byte >= CH_ZERO) && (pattern_byte <= CH_NINE);
  assign clear_acc = (ctx.state == S_BRACE) || (ctx.state == S_BRACKET);
  assign acc_base  = clear_acc ? '0 : ctx.acc;

  rpt_digit_acc u_digit (
    .base       (acc_base),
    .digit_char (pattern_byte),
    .result     (acc_digit)
  );

  always_comb begin
    ctx_next     = ctx;
    ctx_next.pos = ctx.pos + POS_W'(1);
    err_syntax   = 1'b0;
    emit         = 1'b0;
    kind         = KIND_MATCH;
    ch           = 8'd0;
    num          = '0;
    tstart       = '0;
    tlen         = '0;
    if (clear_acc) begin
      ctx_next.acc = '0;
    end
    if (pattern_byte == CH_NUL || ctx.pos >= POS_W'(MAX_PATTERN_LEN)) begin
      err_syntax = 1'b1;
    end else begin
      unique case (ctx.state)
        S_IDLE: begin
          if (pattern_byte == CH_DOLLAR) ctx_next.state = S_DOLLAR;
          else err_syntax = 1'b1;
        end
        S_DOLLAR: begin
          if (pattern_byte == CH_QUOTE) begin
            ctx_next.state     = S_LIT;
            ctx_next.lit_start = ctx.pos + POS_W'(1);
          end else if (pattern_byte == CH_LBRACE) ctx_next.state = S_BRACE;
          else if (pattern_byte == CH_LBRACK) ctx_next.state = S_BRACKET;
          else err_syntax = 1'b1;
        end
        S_LIT: begin
          if (pattern_byte == CH_QUOTE) begin
            emit           = 1'b1;
            kind           = KIND_MATCH;
            ctx_next.state = S_IDLE;
            tstart         = ctx.lit_start;
            tlen           = ctx.pos - ctx.lit_start;
          end
        end
        S_BRACE: begin
          if (pattern_byte == CH_RBRACE) begin
            emit           = 1'b1;
            kind           = KIND_CAP_END;
            ctx_next.state = S_IDLE;
          end else if (pattern_byte == CH_QUOTE) ctx_next.state = S_CC_CH;
          else if (is_dig) begin
            ctx_next.acc   = acc_digit;
            ctx_next.state = S_CL_NUM;
          end else err_syntax = 1'b1;
        end
        S_CC_CH: begin
          ctx_next.held  = pattern_byte;
          ctx_next.state = S_CC_Q;
        end
        S_FF_CH: begin
          ctx_next.held  = pattern_byte;
          ctx_next.state = S_FF_Q;
        end
        S_FR_CH: begin
          ctx_next.held  = pattern_byte;
          ctx_next.state = S_FR_Q;
        end
        S_CC_Q: begin
          if (pattern_byte == CH_QUOTE) ctx_next.state = S_CC_B;
          else err_syntax = 1'b1;
        end
        S_FF_Q: begin
          if (pattern_byte == CH_QUOTE) ctx_next.state = S_FF_B;
          else err_syntax = 1'b1;
        end
        S_FR_Q: begin
          if (pattern_byte == CH_QUOTE) ctx_next.state = S_FR_B;
          else err_syntax = 1'b1;
        end
        S_CC_B: begin
          if (pattern_byte == CH_RBRACE) begin
            emit           = 1'b1;
            kind           = KIND_CAP_CHAR;
            ch             = ctx.held;
            ctx_next.state = S_IDLE;
          end else err_syntax = 1'b1;
        end
        S_FF_B, S_FR_B: begin
          if (pattern_byte == CH_RBRACK) begin
            emit           = 1'b1;
            kind           = (ctx.state == S_FF_B) ? KIND_FIND_FWD : KIND_FIND_REV;
            ch             = ctx.held;
            ctx_next.state = S_IDLE;
          end else err_syntax = 1'b1;
        end
        S_CL_NUM: begin
          if (is_dig) ctx_next.acc = acc_digit;
          else if (pattern_byte == CH_RBRACE && ctx.acc != '0) begin
            emit           = 1'b1;
            kind           = KIND_CAP_LEN;
            num            = ctx.acc;
            ctx_next.state = S_IDLE;
          end else err_syntax = 1'b1;
        end
        S_BRACKET: begin
          if (pattern_byte == CH_GT) ctx_next.state = S_FWD;
          else if (pattern_byte == CH_LT) ctx_next.state = S_REV;
          else if (pattern_byte == CH_E) ctx_next.state = S_E1;
          else if (is_dig) begin
            ctx_next.acc   = acc_digit;
            ctx_next.state = S_ABS_NUM;
          end else err_syntax = 1'b1;
        end
        S_FWD, S_REV: begin
          if (pattern_byte == CH_QUOTE) begin
            ctx_next.state = (ctx.state == S_FWD) ? S_FF_CH : S_FR_CH;
          end else if (is_dig) begin
            ctx_next.acc   = acc_digit;
            ctx_next.state = (ctx.state == S_FWD) ? S_JF_NUM : S_JB_NUM;
          end else if (pattern_byte == CH_RBRACK) begin
            emit           = 1'b1;
            kind           = (ctx.state == S_FWD) ? KIND_JUMP_FWD : KIND_JUMP_BACK;
            ctx_next.state = S_IDLE;
          end else err_syntax = 1'b1;
        end
        S_JF_NUM, S_JB_NUM, S_END_NUM, S_ABS_NUM: begin
          if (is_dig) ctx_next.acc = acc_digit;
          else if (pattern_byte == CH_RBRACK) begin
            emit           = 1'b1;
            num            = ctx.acc;
            ctx_next.state = S_IDLE;
            priority case (ctx.state)
              S_JF_NUM:  kind = KIND_JUMP_FWD;
              S_JB_NUM:  kind = KIND_JUMP_BACK;
              S_END_NUM: kind = KIND_JUMP_END;
              default:   kind = KIND_JUMP_ABS;
            endcase
          end else err_syntax = 1'b1;
        end
        S_E1: begin
          if (pattern_byte == CH_N) ctx_next.state = S_E2;
          else err_syntax = 1'b1;
        end
        S_E2: begin
          if (pattern_byte == CH_D) ctx_next.state = S_END_AFTER;
          else err_syntax = 1'b1;
        end
        S_END_AFTER: begin
          if (pattern_byte == CH_MINUS) begin
            ctx_next.acc   = '0;
            ctx_next.state = S_END_NUM;
          end else if (pattern_byte == CH_RBRACK) begin
            emit           = 1'b1;
            kind           = KIND_JUMP_END;
            ctx_next.state = S_IDLE;
          end else err_syntax = 1'b1;
        end
        default: err_syntax = 1'b1;
      endcase
    end
    // advance the token count with every token that closes
    if (emit) begin
      ctx_next.tokens = ctx.tokens + TOK_W'(1);
    end
  end

  always_comb begin
    err = err_syntax
        || (emit && ctx.tokens >= TOK_W'(MAX_TOKENS))
        || (end_of_pattern && ctx_next.state != S_IDLE);
    if (err) begin
      tok              = '0;
      tok.syntax_error = 1'b1;
      tok.final_result = 1'b1;
    end else begin
      tok.token_kind   = kind;
      tok.syntax_error = 1'b0;
      tok.target_char  = ch;
      tok.number_value = num;
      tok.text_start   = tstart[TEXT_W-1:0];
      tok.text_length  = tlen[TEXT_W-1:0];
      tok.token_index  = ctx.tokens[INDEX_W-1:0];
      tok.final_result = end_of_pattern;
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_route_pattern_tokenizer_core.sv
// Self-checking testbench for route_pattern_tokenizer_core with a built-in token predictor.
module tb_route_pattern_tokenizer_core;
  import rpt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TOTAL_BYTES  = 1650;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } in_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpt_in_if  pin();
  rpt_out_if tok();

  route_pattern_tokenizer_core u_dut (
    .clk(clk),
    .rst(rst),
    .pattern(pin),
    .token(tok)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_word_t   byte_stream[$];
  logic [7:0] pat_buf[$];
  token_t     expected_tokens[$];

  int   bytes_total = 0;
  int   bytes_in = 0;
  int   words_checked = 0;
  int   reject_words = 0;
  int   fails = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic byte_taken = 1'b0;

  // lexer copy used for prediction
  lex_state_t  lx_state;
  logic [31:0] lx_num;
  logic [7:0]  lx_held;
  int          lx_pos;
  int          lx_lit_start;
  int          lx_count;
  bit          lx_dropping;

  task automatic clear_pattern();
    lx_state = S_IDLE;
    lx_num = '0;
    lx_held = '0;
    lx_pos = 0;
    lx_lit_start = 0;
    lx_count = 0;
    lx_dropping = 1'b0;
  endtask

  function automatic bit dec_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // decimal shift-in, pinned at all ones on overflow
  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] wide;
    wide = {4'd0, acc} * 36'd10 + {28'd0, c - CH_ZERO};
    return (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    lex_state_t nxt;
    logic       bad;
    logic       fire;
    token_t     t;
    nxt = lx_state;
    bad = 1'b0;
    fire = 1'b0;
    t = '0;
    if (lx_dropping) begin
      if (last) clear_pattern();
    end else begin
      if (c == CH_NUL || lx_pos >= MAX_PATTERN_LEN) begin
        bad = 1'b1;
      end else begin
        case (lx_state)
          S_IDLE: if (c == CH_DOLLAR) nxt = S_DOLLAR; else bad = 1'b1;
          S_DOLLAR: begin
            if (c == CH_QUOTE) begin
              nxt = S_LIT;
              lx_lit_start = lx_pos + 1;
            end else if (c == CH_LBRACE) nxt = S_BRACE;
            else if (c == CH_LBRACK) nxt = S_BRACKET;
            else bad = 1'b1;
          end
          S_LIT: begin
            if (c == CH_QUOTE) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.token_kind = KIND_MATCH;
              t.text_start = 12'(lx_lit_start);
              t.text_length = 12'(lx_pos - lx_lit_start);
            end
          end
          S_BRACE: begin
            lx_num = '0;
            if (c == CH_RBRACE) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.token_kind = KIND_CAP_END;
            end else if (c == CH_QUOTE) nxt = S_CC_CH;
            else if (dec_char(c)) begin
              lx_num = add_digit(lx_num, c);
              nxt = S_CL_NUM;
            end else bad = 1'b1;
          end
          S_CC_CH: begin
            lx_held = c;
            nxt = S_CC_Q;
          end
          S_FF_CH: begin
            lx_held = c;
            nxt = S_FF_Q;
          end
          S_FR_CH: begin
            lx_held = c;
            nxt = S_FR_Q;
          end
          S_CC_Q: if (c == CH_QUOTE) nxt = S_CC_B; else bad = 1'b1;
          S_FF_Q: if (c == CH_QUOTE) nxt = S_FF_B; else bad = 1'b1;
          S_FR_Q: if (c == CH_QUOTE) nxt = S_FR_B; else bad = 1'b1;
          S_CC_B, S_FF_B, S_FR_B: begin
            if ((lx_state == S_CC_B) ? (c == CH_RBRACE) : (c == CH_RBRACK)) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.target_char = lx_held;
              t.token_kind = (lx_state == S_CC_B) ? KIND_CAP_CHAR :
                             (lx_state == S_FF_B) ? KIND_FIND_FWD : KIND_FIND_REV;
            end else bad = 1'b1;
          end
          S_CL_NUM: begin
            if (dec_char(c)) lx_num = add_digit(lx_num, c);
            else if (c == CH_RBRACE && lx_num != 0) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.token_kind = KIND_CAP_LEN;
              t.number_value = lx_num;
            end else bad = 1'b1;
          end
          S_BRACKET: begin
            lx_num = '0;
            if (c == CH_GT) nxt = S_FWD;
            else if (c == CH_LT) nxt = S_REV;
            else if (c == CH_E) nxt = S_E1;
            else if (dec_char(c)) begin
              lx_num = add_digit(lx_num, c);
              nxt = S_ABS_NUM;
            end else bad = 1'b1;
          end
          S_FWD, S_REV: begin
            if (c == CH_QUOTE) nxt = (lx_state == S_FWD) ? S_FF_CH : S_FR_CH;
            else if (dec_char(c)) begin
              lx_num = add_digit(lx_num, c);
              nxt = (lx_state == S_FWD) ? S_JF_NUM : S_JB_NUM;
            end else if (c == CH_RBRACK) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.token_kind = (lx_state == S_FWD) ? KIND_JUMP_FWD : KIND_JUMP_BACK;
            end else bad = 1'b1;
          end
          S_JF_NUM, S_JB_NUM, S_END_NUM, S_ABS_NUM: begin
            if (dec_char(c)) lx_num = add_digit(lx_num, c);
            else if (c == CH_RBRACK) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.number_value = lx_num;
              t.token_kind = (lx_state == S_JF_NUM) ? KIND_JUMP_FWD :
                             (lx_state == S_JB_NUM) ? KIND_JUMP_BACK :
                             (lx_state == S_END_NUM) ? KIND_JUMP_END : KIND_JUMP_ABS;
            end else bad = 1'b1;
          end
          S_E1: if (c == CH_N) nxt = S_E2; else bad = 1'b1;
          S_E2: if (c == CH_D) nxt = S_END_AFTER; else bad = 1'b1;
          S_END_AFTER: begin
            if (c == CH_MINUS) begin
              lx_num = '0;
              nxt = S_END_NUM;
            end else if (c == CH_RBRACK) begin
              fire = 1'b1;
              nxt = S_IDLE;
              t.token_kind = KIND_JUMP_END;
            end else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      if (!bad && fire && lx_count >= MAX_TOKENS) bad = 1'b1;
      if (!bad && last && nxt != S_IDLE) bad = 1'b1;
      if (bad) begin
        t = '0;
        t.syntax_error = 1'b1;
        t.final_result = 1'b1;
        expected_tokens.push_back(t);
        clear_pattern();
        lx_dropping = !last;
      end else begin
        lx_state = nxt;
        lx_pos++;
        if (fire) begin
          t.token_index = 8'(lx_count);
          t.final_result = last;
          expected_tokens.push_back(t);
          lx_count++;
          if (last) clear_pattern();
        end
      end
    end
  endtask

  task automatic check_word(input token_t got);
    token_t want;
    if (got.syntax_error === 1'b1) reject_words++;
    if (expected_tokens.size() == 0) begin
      $error("token word with nothing expected: kind %0d, syntax_error %0b",
             got.token_kind, got.syntax_error);
      fails++;
    end else begin
      want = expected_tokens.pop_front();
      words_checked++;
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
        fails++;
      end
      if (got.syntax_error !== want.syntax_error) begin
        $error("syntax_error: expected %0b, got %0b", want.syntax_error, got.syntax_error);
        fails++;
      end
      if (got.target_char !== want.target_char) begin
        $error("target_char: expected %0h, got %0h", want.target_char, got.target_char);
        fails++;
      end
      if (got.number_value !== want.number_value) begin
        $error("number_value: expected %0d, got %0d", want.number_value, got.number_value);
        fails++;
      end
      if (got.text_start !== want.text_start) begin
        $error("text_start: expected %0d, got %0d", want.text_start, got.text_start);
        fails++;
      end
      if (got.text_length !== want.text_length) begin
        $error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
        fails++;
      end
      if (got.token_index !== want.token_index) begin
        $error("token_index: expected %0d, got %0d", want.token_index, got.token_index);
        fails++;
      end
      if (got.final_result !== want.final_result) begin
        $error("final_result: expected %0b, got %0b", want.final_result, got.final_result);
        fails++;
      end
    end
  endtask

  // ---------------- pattern building ----------------

  task automatic put_byte(input logic [7:0] c);
    pat_buf.push_back(c);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) pat_buf.push_back(s[i]);
  endtask

  task automatic flush_pattern();
    in_word_t w;
    for (int i = 0; i < pat_buf.size(); i++) begin
      w.b = pat_buf[i];
      w.last = (i == pat_buf.size() - 1);
      byte_stream.push_back(w);
    end
    pat_buf.delete();
  endtask

  function automatic logic [7:0] lit_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] any_char();
    return ($urandom_range(0, 63) == 0) ? CH_NUL : 8'($urandom_range(1, 255));
  endfunction

  function automatic string number_text(input bit may_be_empty);
    string s;
    s = "";
    case ($urandom_range(0, 6))
      0: s = $sformatf("%0d", $urandom_range(0, 9));
      1: s = $sformatf("%0d", $urandom_range(10, 99999));
      2: s = $sformatf("%0d", $urandom());
      3: s = $urandom_range(0, 1) ? "4294967295" : "4294967296";
      4: begin
        repeat ($urandom_range(11, 16)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      end
      5: s = $sformatf("00%0d", $urandom_range(0, 9));
      default: s = may_be_empty ? "" : $sformatf("%0d", $urandom_range(1, 500));
    endcase
    return s;
  endfunction

  task automatic put_op(input int k);
    case (k)
      0: begin
        put_str("$'");
        repeat ($urandom_range(0, 6)) put_byte(lit_char());
        put_byte(CH_QUOTE);
      end
      1: put_str("${}");
      2: begin
        put_str("${'");
        put_byte(any_char());
        put_str("'}");
      end
      3: put_str({"${", number_text(1'b0), "}"});
      4: begin
        put_str("$[>'");
        put_byte(any_char());
        put_str("']");
      end
      5: begin
        put_str("$[<'");
        put_byte(any_char());
        put_str("']");
      end
      6: put_str({"$[>", number_text(1'b1), "]"});
      7: put_str({"$[<", number_text(1'b1), "]"});
      8: begin
        if ($urandom_range(0, 2) == 0) put_str("$[END]");
        else put_str({"$[END-", number_text(1'b1), "]"});
      end
      default: put_str({"$[", number_text(1'b0), "]"});
    endcase
  endtask

  // mostly well-formed patterns; some get a byte broken, a zero inserted or the tail cut
  task automatic add_random_pattern();
    int    sel;
    int    pos;
    string marks;
    marks = "${}[]'";
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) put_op($urandom_range(0, 9));
      pos = $urandom_range(0, pat_buf.size() - 1);
      case (sel)
        1: pat_buf[pos] = 8'($urandom_range(0, 255));
        2: pat_buf.insert(pos, CH_NUL);
        3: begin
          repeat ($urandom_range(1, 2)) if (pat_buf.size() > 1) void'(pat_buf.pop_back());
        end
        4: pat_buf[pos] = marks[$urandom_range(0, 5)];
        default: ;
      endcase
    end
    flush_pattern();
  endtask

  function automatic bit no_idling();
    return (bytes_total - bytes_in < 150) || ((bytes_in / 500) % 3 == 2);
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk) begin : drive_bytes
    in_word_t w;
    if (rst) begin
      pin.valid <= 1'b0;
    end else if (!pin.valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        pin.valid <= 1'b0;
      end else if (byte_stream.size() == 0) begin
        pin.valid <= 1'b0;
      end else if (!no_idling() && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 8) - 1;
        pin.valid <= 1'b0;
      end else begin
        w = byte_stream.pop_front();
        pin.valid <= 1'b1;
        pin.pattern_byte <= w.b;
        pin.end_of_pattern <= w.last;
      end
    end
  end

  // receiver: short random stalls plus one long hold-off to back up the input
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      tok.ready <= 1'b0;
    end else if (!hold_done && bytes_in >= 200) begin
      hold_done = 1'b1;
      hold_left = 299;
      tok.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      tok.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      tok.ready <= 1'b0;
    end else if (!no_idling() && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      tok.ready <= 1'b0;
    end else begin
      tok.ready <= 1'b1;
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : watch
    token_t got;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("route_pattern_tokenizer_core test failed");
      $finish;
    end else if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= pin.valid && pin.ready;
      if (tok.valid && tok.ready) begin
        got.token_kind = kind_t'(tok.token_kind);
        got.syntax_error = tok.syntax_error;
        got.target_char = tok.target_char;
        got.number_value = tok.number_value;
        got.text_start = tok.text_start;
        got.text_length = tok.text_length;
        got.token_index = tok.token_index;
        got.final_result = tok.final_result;
        check_word(got);
      end
      if (pin.valid && pin.ready) begin
        tokenize_byte(pin.pattern_byte, pin.end_of_pattern);
        bytes_in++;
      end
    end
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    pin.valid = 1'b0;
    pin.pattern_byte = '0;
    pin.end_of_pattern = 1'b0;
    tok.ready = 1'b0;
    clear_pattern();

    // every token kind, number saturation, and the basic rejects
    put_str("${}");
    flush_pattern();
    put_str("$''");
    flush_pattern();
    put_str("${'");
    put_byte(8'hFF);
    put_str("'}$'ab'");
    flush_pattern();
    put_str("${4294967295}${4294967296}${007}");
    flush_pattern();
    put_str("$[>'a']$[<'");
    put_byte(8'h80);
    put_str("']$[>]$[<]$[>12]$[<99999999999]");
    flush_pattern();
    put_str("$[END]$[END-]$[END-4294967295]$[0]$[4294967295]");
    flush_pattern();
    put_str("${0}$'x'");
    flush_pattern();
    put_str("$'a");
    put_byte(CH_NUL);
    put_str("'");
    flush_pattern();
    put_str("$[EN");
    flush_pattern();
    put_str("q");
    flush_pattern();
    put_str("$[END+1]");
    flush_pattern();

    // one token past the limit; the extra token closes on the flagged byte
    repeat (MAX_TOKENS + 1) put_str("${}");
    flush_pattern();

    while (byte_stream.size() < TOTAL_BYTES) add_random_pattern();
    bytes_total = byte_stream.size();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (bytes_in < bytes_total) @(negedge clk);
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d pattern bytes incl. a pattern that runs past the token limit;",
             bytes_total);
    $display("checked %0d token words, %0d of them syntax rejects.",
             words_checked, reject_words);
    if (fails == 0) begin
      $display("route_pattern_tokenizer_core test passed");
    end else begin
      $display("route_pattern_tokenizer_core test failed");
    end
    $finish;
  end

endmodule
